FILE: hdl/wola_pkg.sv
// Shared constants, types and the window ROM builder for the overlap-add block.
`timescale 1ns / 1ps

package wola_pkg;

   localparam int WINDOW_SIZE = 2048;
   localparam int SAMPLE_BITS = 16;

   localparam int POS_W  = $clog2(WINDOW_SIZE);
   localparam int HOP_W  = 12;
   localparam int HS_W   = $clog2(WINDOW_SIZE + 1);
   localparam int RS_W   = HS_W + 1;
   localparam int IN_W   = 16;
   localparam int OUT_W  = 16;
   localparam int WIN_W  = 16;
   localparam int ACC_W  = 32;
   localparam int PROD_W = IN_W + WIN_W + 1;
   localparam int Q_W    = PROD_W + 1 - WIN_W;

   localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(512);

   // saturation limits of the emitted sum
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned WIN_DEN = 64'(WINDOW_SIZE - 1);

   typedef logic [WIN_W-1:0] win_rom_type [WINDOW_SIZE];

   // sin(pi*i/(N-1)) in Q0.16: truncated Taylor series to x^13 in Q.30
   function automatic logic [WIN_W-1:0] win_value(input longint unsigned i);
      longint unsigned t;
      longint unsigned theta;
      longint unsigned term;
      longint unsigned r;
      longint          acc;
      t     = (i <= WIN_DEN - i) ? i : WIN_DEN - i;
      theta = (PI_Q30 * t) / WIN_DEN;
      term  = theta;
      acc   = longint'(theta);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd6;
      acc   = acc - longint'(term);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd20;
      acc   = acc + longint'(term);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd42;
      acc   = acc - longint'(term);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd72;
      acc   = acc + longint'(term);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd110;
      acc   = acc - longint'(term);
      term  = ((((term * theta) >> 30) * theta) >> 30) / 64'd156;
      acc   = acc + longint'(term);
      if (acc < 0) begin
         acc = 0;
      end
      r = (longint'(acc) + 64'd8192) >> 14;
      if (r > 64'd65535) begin
         r = 64'd65535;
      end
      return WIN_W'(r);
   endfunction

   function automatic win_rom_type win_rom_build();
      win_rom_type rom;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         rom[i] = win_value(64'(i));
      end
      return rom;
   endfunction

endpackage

FILE: hdl/wola_win_rom.sv
// Square-root Hann window ROM with registered read.
`timescale 1ns / 1ps

module wola_win_rom
   import wola_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [POS_W-1:0] rd_addr,
   output logic [WIN_W-1:0] rd_data
);

   localparam win_rom_type WinRom = win_rom_build();

   logic [WIN_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= WinRom[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

FILE: hdl/wola_acc_ram.sv
// Overlap accumulator memory: one write port, one registered read port.
`timescale 1ns / 1ps

module wola_acc_ram
   import wola_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [POS_W-1:0] wr_addr,
   input  logic [ACC_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [POS_W-1:0] rd_addr,
   output logic [ACC_W-1:0] rd_data
);

   logic [ACC_W-1:0] mem [WINDOW_SIZE];
   logic [ACC_W-1:0] data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

FILE: hdl/windowed_overlap_add_top.sv
// Windowed overlap-add synthesis: top level, pipeline control and datapath.
`timescale 1ns / 1ps
// Result on rsp_* after three register stages: ROM/RAM read, product/prior sum, result.
// Throughput: one sample per cycle unless rsp_stall holds it; the accumulator RAM
//   has separate read/write ports; a read-modify-write never blocks the next sample.
// Reset (synchronous): pipeline emptied, frame position 0, hop 512. The
//   accumulator RAM is not swept: until the first frame wraps, reads of it
//   are forced to zero, which matches an all-zero accumulator.

module windowed_overlap_add_top
   import wola_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_out_sample,
   output logic                    rsp_hop_end,
   input  logic                    csr_wr_en,
   input  logic [HOP_W-1:0]        csr_wr_data
);

   // ---------------- control state ----------------
   logic [HOP_W-1:0] hop_ff, hop_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             first_ff, first_in;
   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   logic             v3_ff, v3_in;

   // ---------------- stage 1: after ROM/RAM read ----------------
   logic signed [IN_W-1:0] s1_sample_ff;
   logic [POS_W-1:0]       s1_waddr_ff;
   logic [POS_W-1:0]       s1_raddr_ff;
   logic                   s1_zero_ff;
   logic                   s1_emit_ff;
   logic                   s1_last_ff;
   logic                   s1_fix_ff, s1_fix_in;
   logic [ACC_W-1:0]       s1_fixdata_ff, s1_fixdata_in;

   // ---------------- stage 2: product and prior sum ----------------
   logic signed [Q_W-1:0]   s2_q_ff;
   logic signed [ACC_W-1:0] s2_old_ff;
   logic [POS_W-1:0]        s2_waddr_ff;
   logic                    s2_emit_ff;
   logic                    s2_last_ff;

   // ---------------- stage 3: result register ----------------
   logic signed [OUT_W-1:0] out_sample_ff;
   logic                    hop_end_ff;

   // ---------------- handshake and advance ----------------
   logic accept, adv1, adv2, s3_free, s2_free, s1_free, out_xfer;

   assign out_xfer = v3_ff & ~rsp_stall;
   assign s3_free  = ~v3_ff | ~rsp_stall;
   // items that emit nothing still write back, without a slot in stage 3
   assign adv2     = v2_ff & (s3_free | ~s2_emit_ff);
   assign s2_free  = ~v2_ff | adv2;
   assign adv1     = v1_ff & s2_free;
   assign s1_free  = ~v1_ff | adv1;
   assign req_stall = ~s1_free;
   assign accept   = req_valid & s1_free;

   // ---------------- address generation for the incoming sample ----------------
   logic [HS_W-1:0]  hop_sat;
   logic [RS_W-1:0]  rsum;
   logic [POS_W-1:0] raddr;
   logic             rzero;
   logic             emit;
   logic             last;

   always_comb begin
      if (32'(hop_ff) > 32'(WINDOW_SIZE)) begin
         hop_sat = HS_W'(WINDOW_SIZE);
      end else begin
         hop_sat = HS_W'(hop_ff);
      end
      rsum  = RS_W'(pos_ff) + RS_W'(hop_sat);
      raddr = rsum[POS_W-1:0];
      // past the end of the frame, or an entry not yet written since reset
      rzero = (32'(rsum) >= 32'(WINDOW_SIZE)) | first_ff;
      emit  = HS_W'(pos_ff) < hop_sat;
      last  = (HS_W'(pos_ff) + HS_W'(1)) == hop_sat;
   end

   // ---------------- memories ----------------
   logic [WIN_W-1:0] win_rd;
   logic [ACC_W-1:0] ram_rd;
   logic             wr_en;
   logic [POS_W-1:0] wr_addr;
   logic [ACC_W-1:0] wr_data;

   wola_win_rom u_win_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (win_rd)
   );

   wola_acc_ram u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (raddr),
      .rd_data (ram_rd)
   );

   // ---------------- stage 1 datapath: forwarding and product ----------------
   // A read can miss write-backs of samples ahead of it in the pipe (only for
   // hops near the window length around the frame wrap); those writes are
   // caught here by address compare.
   logic [ACC_W-1:0]         old1;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W:0]   rnd;

   always_comb begin
      if (wr_en && (wr_addr == s1_raddr_ff)) begin
         old1 = wr_data;
      end else if (s1_fix_ff) begin
         old1 = s1_fixdata_ff;
      end else begin
         old1 = ram_rd;
      end
      prod = s1_sample_ff * $signed({1'b0, win_rd});
      // round half up, then floor by 2^16
      rnd  = (PROD_W + 1)'(prod) + (PROD_W + 1)'(32768);
   end

   always_comb begin
      if (accept) begin
         s1_fix_in     = wr_en && (wr_addr == raddr);
         s1_fixdata_in = wr_data;
      end else begin
         s1_fix_in     = s1_fix_ff | (wr_en && (wr_addr == s1_raddr_ff));
         s1_fixdata_in = old1;
      end
   end

   // ---------------- stage 2 datapath: accumulate and saturate ----------------
   logic signed [ACC_W-1:0] sum2;
   logic signed [ACC_W-1:0] sat2;

   always_comb begin
      sum2 = s2_old_ff + ACC_W'(s2_q_ff);
      if (sum2 > SAT_HI) begin
         sat2 = SAT_HI;
      end else if (sum2 < SAT_LO) begin
         sat2 = SAT_LO;
      end else begin
         sat2 = sum2;
      end
   end

   assign wr_en   = adv2;
   assign wr_addr = s2_waddr_ff;
   assign wr_data = sum2;

   // ---------------- control next state ----------------
   always_comb begin
      hop_in   = csr_wr_en ? csr_wr_data : hop_ff;
      pos_in   = pos_ff;
      first_in = first_ff;
      if (accept) begin
         if (32'(pos_ff) == WINDOW_SIZE - 1) begin
            pos_in   = '0;
            first_in = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      v1_in = accept | (v1_ff & ~adv1);
      v2_in = adv1 | (v2_ff & ~adv2);
      v3_in = (adv2 & s2_emit_ff) | (v3_ff & ~out_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff   <= HOP_RESET;
         pos_ff   <= '0;
         first_ff <= 1'b1;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         hop_ff   <= hop_in;
         pos_ff   <= pos_in;
         first_ff <= first_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      s1_fix_ff     <= s1_fix_in;
      s1_fixdata_ff <= s1_fixdata_in;
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_waddr_ff  <= pos_ff;
         s1_raddr_ff  <= raddr;
         s1_zero_ff   <= rzero;
         s1_emit_ff   <= emit;
         s1_last_ff   <= last;
      end
      if (adv1) begin
         s2_q_ff     <= rnd[PROD_W:WIN_W];
         s2_old_ff   <= s1_zero_ff ? '0 : old1;
         s2_waddr_ff <= s1_waddr_ff;
         s2_emit_ff  <= s1_emit_ff;
         s2_last_ff  <= s1_last_ff;
      end
      if (adv2 && s2_emit_ff) begin
         out_sample_ff <= sat2[OUT_W-1:0];
         hop_end_ff    <= s2_last_ff;
      end
   end

   assign rsp_valid      = v3_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_hop_end    = hop_end_ff;

endmodule

FILE: tb/sv/wola_checker.sv
// Overlap-add checker: predicts the output stream from observed transfers and compares.
`timescale 1ns / 1ps

module wola_checker
   import wola_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_sample,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_out_sample,
   input  logic                    rsp_hop_end,
   input  logic                    csr_wr_en,
   input  logic [HOP_W-1:0]        csr_wr_data,
   output int                      errors,
   output int                      due_count
);

   localparam int     MAX_SHOWN = 10;
   localparam longint SUM_MAX   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SUM_MIN   = -SUM_MAX - 1;

   typedef struct packed {
      logic signed [OUT_W-1:0] sample;
      logic                    hop_end;
   } out_item_type;

   logic [WIN_W-1:0]        sqrt_hann [WINDOW_SIZE];
   logic signed [ACC_W-1:0] sums [WINDOW_SIZE];
   int unsigned             frame_pos;
   logic [HOP_W-1:0]        hop;
   out_item_type            due_samples [$];

   // sqrt-Hann tap in Q0.16: Taylor sine to x^13 in Q.30, symmetric about the center
   function automatic logic [WIN_W-1:0] hann_tap(input int unsigned i);
      longint unsigned last;
      longint unsigned t;
      longint unsigned theta;
      longint unsigned term;
      longint          total;
      last  = 64'(WINDOW_SIZE - 1);
      t     = (i <= last - i) ? i : last - i;
      theta = (PI_Q30 * t) / last;
      term  = theta;
      total = longint'(theta);
      for (int k = 1; k <= 6; k++) begin
         term = (((term * theta) >> 30) * theta) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            total = total - longint'(term);
         end else begin
            total = total + longint'(term);
         end
      end
      if (total < 0) begin
         total = 0;
      end
      t = ($unsigned(total) + 64'd8192) >> 14;
      return (t > 64'd65535) ? {WIN_W{1'b1}} : WIN_W'(t);
   endfunction

   // one frame sample: weight, add the entry one hop ahead, write back in place
   task automatic overlap_add(input logic signed [IN_W-1:0] s);
      int unsigned             eff_hop;
      longint                  weighted;
      logic signed [ACC_W-1:0] carried;
      logic signed [ACC_W-1:0] total;
      out_item_type            item;
      eff_hop  = (hop > WINDOW_SIZE) ? WINDOW_SIZE : hop;
      weighted = (longint'(s) * longint'({1'b0, sqrt_hann[frame_pos]}) + 32768) >>> 16;
      carried  = (frame_pos + eff_hop < WINDOW_SIZE) ? sums[frame_pos + eff_hop] : '0;
      total    = carried + ACC_W'(weighted);
      sums[frame_pos] = total;
      if (frame_pos < eff_hop) begin
         if (total > SUM_MAX) begin
            item.sample = OUT_W'(SUM_MAX);
         end else if (total < SUM_MIN) begin
            item.sample = OUT_W'(SUM_MIN);
         end else begin
            item.sample = OUT_W'(total);
         end
         item.hop_end = (frame_pos == eff_hop - 1);
         due_samples.push_back(item);
      end
      frame_pos = (frame_pos + 1) % WINDOW_SIZE;
   endtask

   task automatic check_output();
      out_item_type want;
      if (due_samples.size() == 0) begin
         errors++;
         if (errors <= MAX_SHOWN) begin
            $display("wola_checker: result with none due: out_sample %0d hop_end %0b",
                     rsp_out_sample, rsp_hop_end);
         end
      end else begin
         want = due_samples.pop_front();
         if (rsp_out_sample !== want.sample || rsp_hop_end !== want.hop_end) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
               $display("wola_checker: out_sample %0d hop_end %0b, expected %0d %0b",
                        rsp_out_sample, rsp_hop_end, want.sample, want.hop_end);
            end
         end
      end
   endtask

   initial begin
      errors = 0;
      foreach (sqrt_hann[i]) begin
         sqrt_hann[i] = hann_tap(i);
      end
   end

   // outputs first: a result never belongs to a sample of the same edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (sums[i]) begin
            sums[i] = '0;
         end
         frame_pos = 0;
         hop       = HOP_RESET;
         due_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_output();
         end
         if (req_valid && !req_stall) begin
            overlap_add(req_sample);
         end
         if (csr_wr_en) begin
            hop = csr_wr_data;
         end
      end
      due_count <= due_samples.size();
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the overlap-add block.
`timescale 1ns / 1ps

module tb;
   import wola_pkg::*;

   localparam int PIPE_LATENCY   = 3;                  // input transfer to earliest result transfer
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 5;   // covers samples that emit nothing
   localparam int RANDOM_SAMPLES = 1578;               // about 1600 samples with the directed ones
   localparam int CYCLE_LIMIT    = 200000;
   localparam int IDLE_PCT       = 11;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [IN_W-1:0]  req_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [OUT_W-1:0] rsp_out_sample;
   logic                    rsp_hop_end;
   logic                    csr_wr_en;
   logic [HOP_W-1:0]        csr_wr_data;

   int          errors;
   int          due_count;
   int          cycles;
   bit          feed_gaps;   // sender idles at random while set
   int unsigned feed_pos;    // frame position of the next sample, used to aim hops

   // full-scale and sign-boundary values, sent first around the window's zero tap
   logic [IN_W-1:0] corner_samples [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                           16'h0001, 16'h5555, 16'hAAAA, 16'h7FFE};

   always #5 clock = ~clock;

   windowed_overlap_add_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_hop_end    (rsp_hop_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   wola_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_hop_end    (rsp_hop_end),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .errors         (errors),
      .due_count      (due_count)
   );

   // Receiver back-pressure: ~11% stall, none during a long window mid-run.
   // cycles moves on the rising edge, so reading it here is race free.
   always @(negedge clock) begin
      rsp_stall <= !(cycles >= 700 && cycles < 1400) && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Mostly random words, with a heavy share of full scale to reach the ends
   // of the output range, and some tiny values near zero.
   function automatic logic [IN_W-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 16'h7FFF;
      end
      if (r < 20) begin
         return 16'h8000;
      end
      if (r < 30) begin
         return IN_W'(int'($urandom_range(0, 32)) - 16);
      end
      return IN_W'($urandom);
   endfunction

   // Hops: mostly legal ones, many aimed just past the current position so the
   // hop end falls inside the coming phase; some zero or above the window.
   function automatic logic [HOP_W-1:0] pick_hop();
      int unsigned ahead;
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return HOP_W'(1);
         end
         2: begin
            return HOP_W'(WINDOW_SIZE);
         end
         3: begin
            return HOP_W'($urandom_range(WINDOW_SIZE + 1, (1 << HOP_W) - 1));
         end
         4, 5, 6: begin
            ahead = feed_pos + $urandom_range(1, 300);
            return HOP_W'((ahead > WINDOW_SIZE) ? WINDOW_SIZE : ahead);
         end
         default: begin
            return HOP_W'($urandom_range(1, WINDOW_SIZE));
         end
      endcase
   endfunction

   // One input transfer. Valid is only touched on falling edges, once per edge,
   // so back-to-back samples keep it high without a glitch.
   task automatic push_sample(input logic [IN_W-1:0] s);
      @(negedge clock);
      while (feed_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      feed_pos = (feed_pos + 1) % WINDOW_SIZE;
   endtask

   // Stop sending, wait for every due result, then let the pipeline empty
   // of samples that emit nothing.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Hop register is only written with the block idle.
   task automatic set_hop(input logic [HOP_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Watchdog: ends a hung run.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned sent;
      int unsigned phase_len;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      feed_gaps   = 1'b1;
      feed_pos    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed. Reset hop of 512: every sample here is emitted.
      foreach (corner_samples[i]) begin
         push_sample(corner_samples[i]);
      end
      // Short hop: positions 8 and 9 emit (9 marks the hop end), 10 and 11 are silent.
      set_hop(HOP_W'(10));
      repeat (4) push_sample(pick_sample());
      // Zero hop: nothing emitted, entries accumulate in place.
      set_hop('0);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(pick_sample());
      // Largest register value: hop clamps to the window, everything emitted.
      set_hop({HOP_W{1'b1}});
      repeat (3) push_sample(pick_sample());
      // Hop of exactly the window, then the smallest legal hop (past its end here).
      set_hop(HOP_W'(WINDOW_SIZE));
      repeat (2) push_sample(pick_sample());
      set_hop(HOP_W'(1));
      repeat (2) push_sample(pick_sample());

      // Random phases, each with a new hop.
      sent = 0;
      while (sent < RANDOM_SAMPLES) begin
         set_hop(pick_hop());
         phase_len = $urandom_range(60, 300);
         for (int n = 0; n < phase_len && sent < RANDOM_SAMPLES; n++) begin
            feed_gaps = !(sent >= 500 && sent < 900);   // long gap-free stretch
            if (sent == 1200) begin
               drain();   // sender holds off until every due result is out
            end
            push_sample(pick_sample());
            sent++;
         end
      end

      drain();
      if (errors == 0 && due_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: windowed_overlap_add_top.f
hdl/wola_pkg.sv
hdl/wola_win_rom.sv
hdl/wola_acc_ram.sv
hdl/windowed_overlap_add_top.sv
tb/sv/wola_checker.sv
tb/sv/tb.sv
